/* rtl/smbt_pkg.sv */
// Package for the SPI master byte transfer block: shared constants, the
// configuration bundle and the sequencer phase type. Depends on nothing.
`timescale 1ns / 1ps
package smbt_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned NUM_SELECTS_DEF = 3;
  localparam int unsigned FRAME_BITS_DEF  = 8;

  // Fixed field widths.
  localparam int unsigned SEL_W  = 2;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // Depth of both internal queues.
  localparam int unsigned FIFO_DEPTH = 2;

  // Register reset values.
  localparam logic [TICK_W-1:0] HIGH_TICKS_RST = 16'd160;
  localparam logic [TICK_W-1:0] LOW_TICKS_RST  = 16'd2;

  // Register index, taken from paddr bit 2.
  localparam logic REG_HIGH_TICKS = 1'b0;
  localparam logic REG_LOW_TICKS  = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_e;

endpackage

/* rtl/smbt_fifo.sv */
// Small register queue used between the front end and the sequencer and
// on the result side. Depends on smbt_pkg for its depth.
`timescale 1ns / 1ps
module smbt_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned DEPTH = smbt_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/smbt_front.sv */
// Front end: takes ticks from the input queue port, decodes the slave
// number into a select mask and queues the tick. Depends on smbt_pkg, smbt_fifo.
`timescale 1ns / 1ps
module smbt_front #(
  parameter int unsigned NUM_SELECTS = smbt_pkg::NUM_SELECTS_DEF,
  parameter int unsigned FRAME_BITS  = smbt_pkg::FRAME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic                       start_req_i,
  input  logic [FRAME_BITS-1:0]      tx_byte_i,
  input  logic [smbt_pkg::SEL_W-1:0] slave_select_i,
  input  logic                       miso_i,
  output logic                       q_valid_o,
  input  logic                       q_pop_i,
  output logic                       q_start_o,
  output logic [FRAME_BITS-1:0]      q_tx_o,
  output logic [NUM_SELECTS-1:0]     q_mask_o,
  output logic                       q_miso_o
);

  localparam int unsigned QW = 2 + FRAME_BITS + NUM_SELECTS;

  logic [NUM_SELECTS-1:0] sel_mask;
  logic [QW-1:0]          wdata, rdata;
  logic                   q_empty;

  // A slave number outside 1..NUM_SELECTS decodes to an empty mask.
  always_comb begin
    for (int k = 0; k < NUM_SELECTS; k++) begin
      sel_mask[k] = (32'(slave_select_i) == 32'(k + 1));
    end
  end

  assign wdata = {start_req_i, tx_byte_i, sel_mask, miso_i};

  smbt_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (wdata),
    .full_o  (full_o),
    .pop_i   (q_pop_i),
    .rdata_o (rdata),
    .empty_o (q_empty)
  );

  assign q_valid_o = !q_empty;
  assign {q_start_o, q_tx_o, q_mask_o, q_miso_o} = rdata;

endmodule

/* rtl/smbt_engine.sv */
// Back end: the bit sequencer that turns each queued tick into pin levels,
// and the result queue. Depends on smbt_pkg, smbt_fifo.
`timescale 1ns / 1ps
module smbt_engine #(
  parameter int unsigned NUM_SELECTS = smbt_pkg::NUM_SELECTS_DEF,
  parameter int unsigned FRAME_BITS  = smbt_pkg::FRAME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  smbt_pkg::cfg_t         cfg_i,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  logic                   q_start_i,
  input  logic [FRAME_BITS-1:0]  q_tx_i,
  input  logic [NUM_SELECTS-1:0] q_mask_i,
  input  logic                   q_miso_i,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic                   sck_o,
  output logic                   mosi_o,
  output logic [NUM_SELECTS-1:0] cs_n_o,
  output logic                   busy_res_o,
  output logic                   done_res_o,
  output logic [FRAME_BITS-1:0]  rx_byte_o
);

  localparam int unsigned BIT_W  = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam int unsigned TW     = smbt_pkg::TICK_W;
  localparam int unsigned RW     = 4 + NUM_SELECTS + FRAME_BITS;
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(FRAME_BITS - 1);

  smbt_pkg::phase_e       phase_q, phase_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [TW-1:0]          tick_q, tick_d;
  logic [FRAME_BITS-1:0]  tx_q, tx_d;
  logic [FRAME_BITS-1:0]  rx_q, rx_d;
  logic [NUM_SELECTS-1:0] mask_q, mask_d;

  logic [TW-1:0]          hi, lo;
  logic                   step, out_full;
  logic                   done, busy, sck, mosi;
  logic [FRAME_BITS-1:0]  rx_out;
  logic [NUM_SELECTS-1:0] cs_n;
  logic [RW-1:0]          res_wdata, res_rdata;

  // A zero tick count behaves as one.
  assign hi = (cfg_i.high_ticks == '0) ? TW'(1) : cfg_i.high_ticks;
  assign lo = (cfg_i.low_ticks == '0) ? TW'(1) : cfg_i.low_ticks;

  assign step    = q_valid_i && !out_full;
  assign q_pop_o = step;

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    tick_d  = tick_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    mask_d  = mask_q;
    done    = 1'b0;
    rx_out  = '0;

    unique case (phase_q)
      smbt_pkg::PH_IDLE: begin
        if (q_start_i) begin
          mask_d  = q_mask_i;
          tx_d    = q_tx_i;
          rx_d    = '0;
          bit_d   = LAST_BIT;
          phase_d = smbt_pkg::PH_HIGH;
          tick_d  = TW'(1);
        end
      end
      smbt_pkg::PH_HIGH: begin
        if (tick_q >= hi) begin
          phase_d = smbt_pkg::PH_LOW;
          tick_d  = TW'(1);
        end else begin
          tick_d = tick_q + TW'(1);
        end
      end
      smbt_pkg::PH_LOW: begin
        if (tick_q >= lo) begin
          bit_d   = bit_q - BIT_W'(1);
          phase_d = smbt_pkg::PH_HIGH;
          tick_d  = TW'(1);
        end else begin
          tick_d = tick_q + TW'(1);
        end
      end
      default: begin
        phase_d = smbt_pkg::PH_IDLE;
        tick_d  = '0;
        bit_d   = LAST_BIT;
      end
    endcase

    // Sample MISO on the last low tick; the final bit ends the frame.
    if (phase_d == smbt_pkg::PH_LOW && tick_d >= lo) begin
      rx_d = (rx_q << 1) | FRAME_BITS'(q_miso_i);
      if (bit_d == '0) begin
        done    = 1'b1;
        rx_out  = rx_d;
        phase_d = smbt_pkg::PH_IDLE;
        tick_d  = '0;
        bit_d   = LAST_BIT;
      end
    end

    busy = (phase_d != smbt_pkg::PH_IDLE);
    sck  = (phase_d == smbt_pkg::PH_HIGH);
    mosi = busy && tx_d[bit_d];
    cs_n = busy ? ~mask_d : '1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= smbt_pkg::PH_IDLE;
      bit_q   <= LAST_BIT;
      tick_q  <= '0;
      tx_q    <= '0;
      rx_q    <= '0;
      mask_q  <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      mask_q  <= mask_d;
    end
  end

  assign res_wdata = {sck, mosi, cs_n, busy, done, rx_out};

  smbt_fifo #(
    .WIDTH (RW)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .wdata_i (res_wdata),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .rdata_o (res_rdata),
    .empty_o (empty_o)
  );

  assign {sck_o, mosi_o, cs_n_o, busy_res_o, done_res_o, rx_byte_o} = res_rdata;

  // A completed frame always leaves the sequencer idle.
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && done |=> phase_q == smbt_pkg::PH_IDLE)
    else $error("sequencer not idle after frame end");

  // While idle the bit counter is parked at the first bit.
  a_idle_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == smbt_pkg::PH_IDLE |-> bit_q == LAST_BIT && tick_q == '0)
    else $error("idle sequencer with stale counters");

  // A running bit phase never has a zero tick count.
  a_tick_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != smbt_pkg::PH_IDLE |-> tick_q != '0)
    else $error("zero tick count in a bit phase");

  // The sequencer only advances when a tick is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(phase_q) && $stable(tick_q) && $stable(bit_q))
    else $error("sequencer moved without a tick");

endmodule

/* rtl/spi_master_byte_transfer_top.sv */
// Top level of the SPI master byte transfer block: register port, front end
// and sequencer. Depends on smbt_pkg, smbt_front, smbt_engine, smbt_fifo.
// A tick is registered in the front-end queue and its result in the result
// queue before it shows on the output ports; the sequencer takes one tick per
// cycle while the result queue has room. Reset (rst_ni, asynchronous,
// active low) empties both queues, parks the sequencer idle and loads
// high_ticks = 160 and low_ticks = 2; no clearing pass is needed.
`timescale 1ns / 1ps
module spi_master_byte_transfer_top #(
  parameter int unsigned NUM_SELECTS = smbt_pkg::NUM_SELECTS_DEF,
  parameter int unsigned FRAME_BITS  = smbt_pkg::FRAME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smbt_pkg::APB_AW-1:0] paddr,
  input  logic [smbt_pkg::APB_DW-1:0] pwdata,
  output logic [smbt_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  // Tick input side
  input  logic                        push,
  output logic                        full,
  input  logic                        start_req_i,
  input  logic [FRAME_BITS-1:0]       tx_byte_i,
  input  logic [smbt_pkg::SEL_W-1:0]  slave_select_i,
  input  logic                        miso_i,
  // Result side
  output logic                        empty,
  input  logic                        pop,
  output logic                        sck_o,
  output logic                        mosi_o,
  output logic [NUM_SELECTS-1:0]      cs_n_o,
  output logic                        busy_res_o,
  output logic                        done_res_o,
  output logic [FRAME_BITS-1:0]       rx_byte_o
);

  localparam int unsigned TW = smbt_pkg::TICK_W;
  localparam int unsigned DW = smbt_pkg::APB_DW;

  smbt_pkg::cfg_t         cfg_q, cfg_d;
  logic                   cfg_wr;
  logic                   q_valid, q_pop, q_start, q_miso;
  logic [FRAME_BITS-1:0]  q_tx;
  logic [NUM_SELECTS-1:0] q_mask;

  // The register port never waits. A write transfer completes in its
  // access cycle; paddr bit 2 picks the register, the low bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        smbt_pkg::REG_HIGH_TICKS: cfg_d.high_ticks = pwdata[TW-1:0];
        smbt_pkg::REG_LOW_TICKS:  cfg_d.low_ticks  = pwdata[TW-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_ticks <= smbt_pkg::HIGH_TICKS_RST;
      cfg_q.low_ticks  <= smbt_pkg::LOW_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read data is the addressed register, zero-extended.
  always_comb begin
    unique case (paddr[2])
      smbt_pkg::REG_HIGH_TICKS: prdata = DW'(cfg_q.high_ticks);
      smbt_pkg::REG_LOW_TICKS:  prdata = DW'(cfg_q.low_ticks);
      default:                  prdata = '0;
    endcase
  end

  // The front end queues each tick with its slave number already decoded
  // into a select mask, so the sequencer and the tick source stall apart.
  smbt_front #(
    .NUM_SELECTS (NUM_SELECTS),
    .FRAME_BITS  (FRAME_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .start_req_i    (start_req_i),
    .tx_byte_i      (tx_byte_i),
    .slave_select_i (slave_select_i),
    .miso_i         (miso_i),
    .q_valid_o      (q_valid),
    .q_pop_i        (q_pop),
    .q_start_o      (q_start),
    .q_tx_o         (q_tx),
    .q_mask_o       (q_mask),
    .q_miso_o       (q_miso)
  );

  // The sequencer consumes one queued tick per cycle whenever its result
  // queue has room, and each tick yields exactly one result transfer.
  smbt_engine #(
    .NUM_SELECTS (NUM_SELECTS),
    .FRAME_BITS  (FRAME_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_start_i  (q_start),
    .q_tx_i     (q_tx),
    .q_mask_i   (q_mask),
    .q_miso_i   (q_miso),
    .empty_o    (empty),
    .pop_i      (pop),
    .sck_o      (sck_o),
    .mosi_o     (mosi_o),
    .cs_n_o     (cs_n_o),
    .busy_res_o (busy_res_o),
    .done_res_o (done_res_o),
    .rx_byte_o  (rx_byte_o)
  );

endmodule

/* bench/tb_spi_master_byte_transfer_top.sv */
// Self-checking bench for the SPI master byte transfer block: stimulus, pin-level
// predictor and scoreboard. Depends on smbt_pkg and spi_master_byte_transfer_top.
`timescale 1ns / 1ps
package smbt_tb_pkg;
  import smbt_pkg::*;

  localparam int unsigned FRAME_W = FRAME_BITS_DEF;
  localparam int unsigned CS_W    = NUM_SELECTS_DEF;

  typedef struct packed {
    logic               start_req;
    logic [FRAME_W-1:0] tx_byte;
    logic [SEL_W-1:0]   slave_select;
    logic               miso;
  } spi_tick_t;

  typedef struct packed {
    logic               sck;
    logic               mosi;
    logic [CS_W-1:0]    cs_n;
    logic               busy;
    logic               done;
    logic [FRAME_W-1:0] rx_byte;
  } pin_sample_t;

  class spi_pin_scoreboard;
    logic [TICK_W-1:0]  high_ticks;
    logic [TICK_W-1:0]  low_ticks;
    phase_e             phase;
    logic [2:0]         bit_idx;
    logic [TICK_W-1:0]  tick_cnt;
    logic [FRAME_W-1:0] tx_shift;
    logic [FRAME_W-1:0] rx_shift;
    logic [SEL_W-1:0]   slave;
    pin_sample_t        expected_pins[$];
    int unsigned        mismatches;
    int unsigned        results_seen;

    function new();
      high_ticks   = HIGH_TICKS_RST;
      low_ticks    = LOW_TICKS_RST;
      phase        = PH_IDLE;
      bit_idx      = 3'(FRAME_W - 1);
      tick_cnt     = '0;
      tx_shift     = '0;
      rx_shift     = '0;
      slave        = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic idx, logic [TICK_W-1:0] value);
      if (idx == REG_HIGH_TICKS) high_ticks = value;
      else low_ticks = value;
    endfunction

    function bit in_frame();
      return phase != PH_IDLE;
    endfunction

    function int unsigned pending();
      return expected_pins.size();
    endfunction

    // Advances the sequencer by one tick and queues the pin levels it yields.
    function void note_tick(spi_tick_t t);
      pin_sample_t r;
      int unsigned hi;
      int unsigned lo;
      hi = (high_ticks == 0) ? 1 : high_ticks;
      lo = (low_ticks == 0) ? 1 : low_ticks;
      r = '0;
      case (phase)
        PH_IDLE: begin
          if (t.start_req) begin
            slave    = t.slave_select;
            tx_shift = t.tx_byte;
            rx_shift = '0;
            bit_idx  = 3'(FRAME_W - 1);
            phase    = PH_HIGH;
            tick_cnt = TICK_W'(1);
          end
        end
        PH_HIGH: begin
          if (tick_cnt >= hi) begin
            phase    = PH_LOW;
            tick_cnt = TICK_W'(1);
          end else begin
            tick_cnt = tick_cnt + 1'b1;
          end
        end
        default: begin
          if (tick_cnt >= lo) begin
            bit_idx  = bit_idx - 1'b1;
            phase    = PH_HIGH;
            tick_cnt = TICK_W'(1);
          end else begin
            tick_cnt = tick_cnt + 1'b1;
          end
        end
      endcase
      // MISO is sampled on the last low tick; the final bit closes the frame.
      if (phase == PH_LOW && tick_cnt >= lo) begin
        rx_shift = {rx_shift[FRAME_W-2:0], t.miso};
        if (bit_idx == 0) begin
          r.done    = 1'b1;
          r.rx_byte = rx_shift;
          phase     = PH_IDLE;
          tick_cnt  = '0;
          bit_idx   = 3'(FRAME_W - 1);
        end
      end
      r.busy = (phase != PH_IDLE);
      r.sck  = (phase == PH_HIGH);
      r.mosi = r.busy ? tx_shift[bit_idx] : 1'b0;
      r.cs_n = '1;
      if (r.busy && slave >= 1 && slave <= CS_W) r.cs_n[slave-1] = 1'b0;
      expected_pins.push_back(r);
    endfunction

    // One line for every mismatch, and a running count.
    task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(pin_sample_t got);
      pin_sample_t want;
      if (expected_pins.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
        results_seen++;
        return;
      end
      want = expected_pins.pop_front();
      if (got.sck !== want.sck)
        report($sformatf("result %0d: sck %b, expected %b", results_seen, got.sck, want.sck));
      if (got.mosi !== want.mosi)
        report($sformatf("result %0d: mosi %b, expected %b", results_seen, got.mosi,
                         want.mosi));
      if (got.cs_n !== want.cs_n)
        report($sformatf("result %0d: cs_n %b, expected %b", results_seen, got.cs_n,
                         want.cs_n));
      if (got.busy !== want.busy)
        report($sformatf("result %0d: busy %b, expected %b", results_seen, got.busy,
                         want.busy));
      if (got.done !== want.done)
        report($sformatf("result %0d: done %b, expected %b", results_seen, got.done,
                         want.done));
      if (got.rx_byte !== want.rx_byte)
        report($sformatf("result %0d: rx_byte %h, expected %h", results_seen, got.rx_byte,
                         want.rx_byte));
      results_seen++;
    endtask
  endclass

endpackage

module tb_spi_master_byte_transfer_top;
  import smbt_pkg::*;
  import smbt_tb_pkg::*;

  // Generous ceiling: roughly a thousand ticks, each of which can wait out a
  // full sender gap and a full receiver stall, plus the register writes.
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [APB_AW-1:0]   paddr          = '0;
  logic [APB_DW-1:0]   pwdata         = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                push           = 1'b0;
  logic                full;
  logic                start_req_i    = 1'b0;
  logic [FRAME_W-1:0]  tx_byte_i      = '0;
  logic [SEL_W-1:0]    slave_select_i = '0;
  logic                miso_i         = 1'b0;
  logic                empty;
  logic                pop            = 1'b0;
  logic                sck_o;
  logic                mosi_o;
  logic [CS_W-1:0]     cs_n_o;
  logic                busy_res_o;
  logic                done_res_o;
  logic [FRAME_W-1:0]  rx_byte_o;

  spi_master_byte_transfer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .start_req_i    (start_req_i),
    .tx_byte_i      (tx_byte_i),
    .slave_select_i (slave_select_i),
    .miso_i         (miso_i),
    .empty          (empty),
    .pop            (pop),
    .sck_o          (sck_o),
    .mosi_o         (mosi_o),
    .cs_n_o         (cs_n_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .rx_byte_o      (rx_byte_o)
  );

  spi_pin_scoreboard sb = new();

  // The bench keeps its own idea of push and pop so that a strobe is never
  // given two nonblocking assignments within one time step.
  bit          push_on;
  bit          pop_on;
  int unsigned tx_run_left;
  bit          tx_run_fast;
  int unsigned rx_run_left;
  bit          rx_run_fast;
  int unsigned cycle_count;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Each side alternates between stretches with no idling at all and
  // stretches where every transfer is preceded by a random wait, so that
  // gaps land on every phase of the SPI frame.
  function automatic int unsigned draw_gap(inout int unsigned run_left, inout bit run_fast);
    if (run_left == 0) begin
      run_fast = ($urandom_range(0, 2) == 0);
      run_left = $urandom_range(10, 60);
    end
    run_left--;
    return run_fast ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic spi_tick_t mk_tick(logic start, logic [FRAME_W-1:0] tx,
                                        logic [SEL_W-1:0] sel, logic miso);
    spi_tick_t t;
    t.start_req    = start;
    t.tx_byte      = tx;
    t.slave_select = sel;
    t.miso         = miso;
    return t;
  endfunction

  // Random ticks are mostly well formed: while the master is idle a start is
  // very likely, so frames follow one another closely; while a frame is
  // running, stray start requests appear now and then as noise and must be
  // ignored. Slave number zero (no select asserted) is drawn as often as the
  // real slaves.
  function automatic spi_tick_t random_tick();
    spi_tick_t t;
    t.tx_byte      = FRAME_W'($urandom_range(0, 255));
    t.slave_select = SEL_W'($urandom_range(0, 3));
    t.miso         = 1'($urandom_range(0, 1));
    if (sb.in_frame()) t.start_req = ($urandom_range(0, 3) == 0);
    else t.start_req = ($urandom_range(0, 7) != 0);
    return t;
  endfunction

  // Offers one tick on the input side and returns once it has been taken.
  // push is left high so that a following tick with no gap goes straight on.
  task automatic send_tick(input spi_tick_t t);
    int unsigned gap;
    gap = draw_gap(tx_run_left, tx_run_fast);
    if (gap != 0) begin
      if (push_on) begin
        push    <= 1'b0;
        push_on  = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    push_on         = 1'b1;
    start_req_i    <= t.start_req;
    tx_byte_i      <= t.tx_byte;
    slave_select_i <= t.slave_select;
    miso_i         <= t.miso;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_tick(t);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_tick(random_tick());
  endtask

  // Plain ticks with no start request until the current frame has ended.
  task automatic run_to_idle();
    while (sb.in_frame())
      send_tick(mk_tick(1'b0, FRAME_W'($urandom_range(0, 255)),
                        SEL_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
  endtask

  // Stops offering ticks and waits until every expected result has arrived.
  task automatic drain();
    if (push_on) begin
      push    <= 1'b0;
      push_on  = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // One register write: setup cycle, then access cycle. The upper half of the
  // data word carries random bits, which the 16-bit registers must drop.
  task automatic write_reg(input logic idx, input logic [TICK_W-1:0] value);
    logic [APB_DW-1:0] word;
    word        = $urandom();
    word[15:0]  = value;
    psel       <= 1'b1;
    penable    <= 1'b0;
    pwrite     <= 1'b1;
    paddr      <= {idx, 2'b00};
    pwdata     <= word;
    @(posedge clk_i);
    penable    <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    sb.write_reg(idx, value);
    // Bus returns to idle before the next setup phase.
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [TICK_W-1:0] hi, input logic [TICK_W-1:0] lo);
    drain();
    write_reg(REG_HIGH_TICKS, hi);
    write_reg(REG_LOW_TICKS, lo);
  endtask

  // Result side: pops at its own pace and hands every accepted result to the
  // scoreboard. Outputs are read straight after the edge, so they still hold
  // the values that the block presented when the transfer took place.
  initial begin
    pin_sample_t got;
    int unsigned gap;
    @(posedge clk_i);
    wait (rst_ni);
    forever begin
      gap = draw_gap(rx_run_left, rx_run_fast);
      if (gap != 0) begin
        if (pop_on) begin
          pop    <= 1'b0;
          pop_on  = 1'b0;
        end
        repeat (gap) @(posedge clk_i);
      end
      pop    <= 1'b1;
      pop_on  = 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      got.sck     = sck_o;
      got.mosi    = mosi_o;
      got.cs_n    = cs_n_o;
      got.busy    = busy_res_o;
      got.done    = done_res_o;
      got.rx_byte = rx_byte_o;
      sb.check_result(got);
    end
  end

  // Stimulus sequence.
  initial begin
    logic [TICK_W-1:0] hi_set[6];
    logic [TICK_W-1:0] lo_set[6];
    hi_set = '{16'd1, 16'd2, 16'd0, 16'd4, 16'd1, 16'd3};
    lo_set = '{16'd1, 16'd3, 16'd0, 16'd1, 16'd5, 16'd2};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timing (160 high, 2 low): an idle tick, then a frame is begun and
    // followed some way into its first long high phase, with stray starts.
    send_tick(mk_tick(1'b0, 8'h00, 2'd0, 1'b0));
    send_tick(mk_tick(1'b1, 8'h81, 2'd1, 1'b1));
    run_random(40);

    // The fastest timing takes over in the middle of that frame.
    set_timing(16'd1, 16'd1);
    run_to_idle();

    // Directed frames. First all ones out to slave 3 with MISO held high,
    // with a start request on every tick while it runs; these must be
    // ignored. The next frame starts on the tick after completion, sends all
    // zeros with slave number zero, so no select may fall, and reads zeros.
    send_tick(mk_tick(1'b1, 8'hFF, 2'd3, 1'b1));
    for (int k = 0; k < 15; k++) send_tick(mk_tick(1'b1, 8'h00, 2'd1, 1'b1));
    send_tick(mk_tick(1'b1, 8'h00, 2'd0, 1'b0));
    for (int k = 0; k < 15; k++) send_tick(mk_tick(1'b0, 8'hFF, 2'd2, 1'b0));

    // Random frames under a spread of timings, zero registers among them.
    // Partway through the second setting the sender holds off until every
    // expected result has come back.
    for (int s = 0; s < 6; s++) begin
      set_timing(hi_set[s], lo_set[s]);
      if (s == 1) begin
        run_random(48);
        drain();
        run_random(47);
      end else begin
        run_random(95);
      end
    end

    // Largest register values. A full frame at these settings would take
    // half a million ticks, so each is exercised only part of the way and
    // then replaced mid-frame; the running counts must then compare against
    // the new, smaller value.
    run_to_idle();
    set_timing(16'hFFFF, 16'd1);
    send_tick(mk_tick(1'b1, 8'h96, 2'd2, 1'b1));
    run_random(60);
    set_timing(16'd1, 16'hFFFF);
    run_random(60);
    set_timing(16'd2, 16'd1);
    run_random(60);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
